>>> rtl/core/sda_pkg.sv
// ----------------------------------------------------------------------------
// sda_pkg
// Shared constants for the signed binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sda_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // Bits retired per double-dabble pipeline stage.
  localparam int unsigned BITS_PER_STAGE = 4;

  // log10(2) scaled by 1e5, for sizing the digit store at elaboration.
  localparam int unsigned LOG10_2_E5 = 30103;

endpackage

>>> rtl/core/sda_if.sv
// ----------------------------------------------------------------------------
// sda_in_if / sda_out_if
// Valid/ready channels carrying the input number and the output characters.
// ----------------------------------------------------------------------------
interface sda_in_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sda_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

>>> rtl/core/signed_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_to_decimal_ascii
// Renders a signed two's complement number as decimal ASCII, MSD first.
// ----------------------------------------------------------------------------
//
//   channel  | dir | payload                 | beat meaning
//   ---------+-----+-------------------------+------------------------------
//   in_ch    | in  | value[VALUE_WIDTH-1:0]  | one number to render
//   out_ch   | out | character[7:0], last    | one character, last marks end
//
// Path: a number passes the sign/magnitude register and the double-dabble
//   pipeline (4 bits per stage), then the serializer loads it and takes one
//   step per digit position (NUM_DIGITS, 10 at 32 bits), leading zeros
//   included, and one more step for a minus sign.
// Throughput is set by the serializer: it takes a new number only once it
//   has emitted the last digit of the number before.
// Reset: rst_n is synchronous, active low; it empties every stage.
// Stalls: each stage advances when the next one is empty or moving; out_ch
//   back-pressure holds the output register and then the whole pipeline.
//
module signed_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input logic        clk,
  input logic        rst_n,
  sda_in_if.sink     in_ch,
  sda_out_if.source  out_ch
);

  // Decimal digits needed for 2^VALUE_WIDTH - 1.
  localparam int unsigned NUM_DIGITS =
    (VALUE_WIDTH * sda_pkg::LOG10_2_E5) / 100000 + 1;
  localparam int unsigned NUM_STAGES =
    (VALUE_WIDTH + sda_pkg::BITS_PER_STAGE - 1) / sda_pkg::BITS_PER_STAGE;
  // Magnitude padded with leading zeros to a whole number of stages.
  localparam int unsigned PAD_WIDTH = NUM_STAGES * sda_pkg::BITS_PER_STAGE;
  localparam int unsigned BCD_WIDTH = 4 * NUM_DIGITS;

  logic                 valid_s [NUM_STAGES+1];
  logic                 ready_s [NUM_STAGES+1];
  logic                 neg_s   [NUM_STAGES+1];
  logic [PAD_WIDTH-1:0] mag_s   [NUM_STAGES+1];
  logic [BCD_WIDTH-1:0] bcd_s   [NUM_STAGES+1];

  // Entry register: sign and unsigned magnitude.
  logic                   in_valid_r;
  logic                   in_neg_r;
  logic [VALUE_WIDTH-1:0] in_mag_r;
  logic                   in_neg;

  assign in_neg      = in_ch.value[VALUE_WIDTH-1];
  assign in_ch.ready = !in_valid_r || ready_s[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_neg_r <= in_neg;
      // modulo 2^W negate: the most negative value maps to 2^(W-1)
      in_mag_r <= in_neg ? (~in_ch.value + 1'b1) : in_ch.value;
    end
  end

  assign valid_s[0] = in_valid_r;
  assign neg_s[0]   = in_neg_r;
  assign mag_s[0]   = PAD_WIDTH'(in_mag_r);
  assign bcd_s[0]   = '0;

  // Double-dabble pipeline.
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    sda_dabble_stage #(
      .MAG_WIDTH  (PAD_WIDTH),
      .NUM_DIGITS (NUM_DIGITS)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (valid_s[k]),
      .up_ready (ready_s[k]),
      .up_neg   (neg_s[k]),
      .up_mag   (mag_s[k]),
      .up_bcd   (bcd_s[k]),
      .dn_valid (valid_s[k+1]),
      .dn_ready (ready_s[k+1]),
      .dn_neg   (neg_s[k+1]),
      .dn_mag   (mag_s[k+1]),
      .dn_bcd   (bcd_s[k+1])
    );
  end

  // Character output: sign, leading-zero skip, digits.
  sda_serializer #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (valid_s[NUM_STAGES]),
    .in_ready      (ready_s[NUM_STAGES]),
    .in_neg        (neg_s[NUM_STAGES]),
    .in_bcd        (bcd_s[NUM_STAGES]),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_character (out_ch.character),
    .out_last      (out_ch.last)
  );

endmodule

>>> rtl/core/sda_dabble_stage.sv
// ----------------------------------------------------------------------------
// sda_dabble_stage
// One pipeline stage of double dabble: shifts four magnitude bits into BCD.
// ----------------------------------------------------------------------------
module sda_dabble_stage #(
  parameter int unsigned MAG_WIDTH  = 32,
  parameter int unsigned NUM_DIGITS = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  logic                      up_neg,
  input  logic [MAG_WIDTH-1:0]      up_mag,
  input  logic [4*NUM_DIGITS-1:0]   up_bcd,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output logic                      dn_neg,
  output logic [MAG_WIDTH-1:0]      dn_mag,
  output logic [4*NUM_DIGITS-1:0]   dn_bcd
);

  logic                    valid_r;
  logic                    neg_r;
  logic [MAG_WIDTH-1:0]    mag_r;
  logic [4*NUM_DIGITS-1:0] bcd_r;
  logic [MAG_WIDTH-1:0]    mag_nxt;
  logic [4*NUM_DIGITS-1:0] bcd_nxt;

  always_comb begin
    mag_nxt = up_mag;
    bcd_nxt = up_bcd;
    for (int s = 0; s < sda_pkg::BITS_PER_STAGE; s++) begin
      // add 3 to any digit of 5 or more, then shift in the next bit
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (bcd_nxt[4*d +: 4] >= 4'd5) begin
          bcd_nxt[4*d +: 4] = bcd_nxt[4*d +: 4] + 4'd3;
        end
      end
      bcd_nxt = {bcd_nxt[4*NUM_DIGITS-2:0], mag_nxt[MAG_WIDTH-1]};
      mag_nxt = {mag_nxt[MAG_WIDTH-2:0], 1'b0};
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      neg_r <= up_neg;
      mag_r <= mag_nxt;
      bcd_r <= bcd_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_neg   = neg_r;
  assign dn_mag   = mag_r;
  assign dn_bcd   = bcd_r;

endmodule

>>> rtl/core/sda_serializer.sv
// ----------------------------------------------------------------------------
// sda_serializer
// Walks the BCD digits of one number and emits sign and digit characters.
// ----------------------------------------------------------------------------
module sda_serializer #(
  parameter int unsigned NUM_DIGITS = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_neg,
  input  logic [4*NUM_DIGITS-1:0] in_bcd,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_character,
  output logic                    out_last
);

  localparam int unsigned CW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [CW-1:0] TOP_IDX = CW'(NUM_DIGITS - 1);

  logic                    busy_r, busy_nxt;
  logic                    neg_pend_r, neg_pend_nxt;
  logic                    started_r, started_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [4*NUM_DIGITS-1:0] bcd_r, bcd_nxt;
  logic                    ov_r, ov_nxt;
  logic [7:0]              char_r, char_nxt;
  logic                    last_r, last_nxt;
  logic                    can_out;
  logic [3:0]              top_digit;

  assign in_ready  = !busy_r;
  assign can_out   = !ov_r || out_ready;
  assign top_digit = bcd_r[4*NUM_DIGITS-1 -: 4];

  always_comb begin
    busy_nxt     = busy_r;
    neg_pend_nxt = neg_pend_r;
    started_nxt  = started_r;
    cnt_nxt      = cnt_r;
    bcd_nxt      = bcd_r;
    ov_nxt       = ov_r && !out_ready;
    char_nxt     = char_r;
    last_nxt     = last_r;
    if (!busy_r) begin
      if (in_valid) begin
        busy_nxt     = 1'b1;
        neg_pend_nxt = in_neg;
        started_nxt  = 1'b0;
        cnt_nxt      = TOP_IDX;
        bcd_nxt      = in_bcd;
      end
    end else if (can_out) begin
      if (neg_pend_r) begin
        ov_nxt       = 1'b1;
        char_nxt     = sda_pkg::CHAR_MINUS;
        last_nxt     = 1'b0;
        neg_pend_nxt = 1'b0;
      end else if (!started_r && top_digit == 4'd0 && cnt_r != '0) begin
        // drop a leading zero
        bcd_nxt = {bcd_r[4*NUM_DIGITS-5:0], 4'd0};
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        ov_nxt      = 1'b1;
        char_nxt    = sda_pkg::CHAR_ZERO + {4'd0, top_digit};
        last_nxt    = (cnt_r == '0);
        started_nxt = 1'b1;
        if (cnt_r == '0) begin
          busy_nxt = 1'b0;
        end else begin
          bcd_nxt = {bcd_r[4*NUM_DIGITS-5:0], 4'd0};
          cnt_nxt = cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      neg_pend_r <= 1'b0;
      started_r  <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      neg_pend_r <= neg_pend_nxt;
      started_r  <= started_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    bcd_r  <= bcd_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_valid     = ov_r;
  assign out_character = char_r;
  assign out_last      = last_r;

`ifndef SYNTH
  a_load_starts_at_top: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy_r && in_valid) |=> (busy_r && cnt_r == TOP_IDX))
    else $error("serializer did not start at the top digit");
  a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && neg_pend_r && can_out) |=>
      (ov_r && char_r == sda_pkg::CHAR_MINUS && !last_r))
    else $error("minus sign not emitted first");
  a_more_to_come: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !last_r) |-> busy_r)
    else $error("non-final character with no number in progress");
`endif

endmodule

>>> verif/signed_to_decimal_ascii_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_to_decimal_ascii_test
// Feeds signed numbers into the converter and checks every character beat
// against typed-in text or a behavioral itoa, idling both channels at random.
// ----------------------------------------------------------------------------
module signed_to_decimal_ascii_test;

  localparam int unsigned VW          = 32;
  localparam int unsigned RANDOM_NUMS = 350;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } char_beat_t;

  // Directed row: a value and, where obvious, its full text.
  typedef struct {
    logic [VW-1:0] value;
    string         text;
  } number_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sda_in_if #(.VALUE_WIDTH(VW)) in_ch ();
  sda_out_if out_ch ();

  signed_to_decimal_ascii #(.VALUE_WIDTH(VW)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #2 clk = ~clk;

  char_beat_t  pending_chars[$];
  int unsigned fail_count = 0;
  int unsigned chars_seen = 0;
  int unsigned nums_sent = 0;
  int unsigned cycle_count = 0;
  bit          quiet_tail = 1'b0;

  // Render one value as character beats, most significant digit first.
  function automatic void render_decimal(input logic [VW-1:0] value);
    logic [VW-1:0] mag;
    logic [3:0]    digs[$];
    char_beat_t    beat;
    begin
      mag = value[VW-1] ? (~value + 1'b1) : value;
      do begin
        digs.push_front(4'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      if (value[VW-1]) begin
        beat.character = sda_pkg::CHAR_MINUS;
        beat.last = 1'b0;
        pending_chars.push_back(beat);
      end
      foreach (digs[k]) begin
        beat.character = sda_pkg::CHAR_ZERO + 8'(digs[k]);
        beat.last = (k == digs.size() - 1);
        pending_chars.push_back(beat);
      end
    end
  endfunction

  // Queue a typed-in expectation; used in place of the predictor for rows with text.
  function automatic void queue_text(input string text);
    char_beat_t beat;
    begin
      for (int k = 0; k < text.len(); k++) begin
        beat.character = text[k];
        beat.last = (k == text.len() - 1);
        pending_chars.push_back(beat);
      end
    end
  endfunction

  // Send one number; hold valid until the beat is taken.
  task automatic send_number(input logic [VW-1:0] value);
    int unsigned gap;
    begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 14);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.value <= value;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      nums_sent++;
    end
  endtask

  // Sink side: random stall bursts, none in the tail.
  initial begin
    int unsigned burst;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 14);
        out_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Compare each accepted character with the oldest expectation.
  always @(posedge clk) begin
    char_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected char expected none actual %0d last %0b",
                 $time, out_ch.character, out_ch.last);
      end else begin
        want = pending_chars.pop_front();
        if (out_ch.character !== want.character) begin
          fail_count++;
          $display("%0t: character expected %0d actual %0d", $time,
                   want.character, out_ch.character);
        end
        if (out_ch.last !== want.last) begin
          fail_count++;
          $display("%0t: last expected %0b actual %0b", $time,
                   want.last, out_ch.last);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  number_row_t directed_rows[] = '{
    '{32'sd0,           "0"},
    '{32'sd1,           "1"},
    '{-32'sd1,          "-1"},
    '{32'sd9,           "9"},
    '{32'sd10,          "10"},
    '{-32'sd10,         "-10"},
    '{32'h7FFF_FFFF,    "2147483647"},
    '{32'h8000_0000,    "-2147483648"},
    '{32'h8000_0001,    "-2147483647"},
    '{32'sd1000000000,  "1000000000"},
    '{32'sd999999999,   "999999999"},
    '{32'hAAAA_AAAA,    ""},
    '{32'h5555_5555,    ""},
    '{32'sd99,          ""},
    '{32'sd100,         ""},
    '{-32'sd999,        ""},
    '{32'h0000_FFFF,    ""},
    '{32'hFFFF_0000,    ""},
    '{32'sd0,           "0"}
  };

  initial begin
    logic [VW-1:0] pick;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: typed text where given, predictor otherwise.
    foreach (directed_rows[r]) begin
      if (directed_rows[r].text.len() != 0) queue_text(directed_rows[r].text);
      else render_decimal(directed_rows[r].value);
      send_number(directed_rows[r].value);
    end

    // Random: mix full-range words with short numbers for varied lengths.
    for (int unsigned n = 0; n < RANDOM_NUMS; n++) begin
      case ($urandom_range(0, 3))
        0: pick = $urandom;
        1: pick = VW'($urandom_range(0, 999));
        2: pick = -VW'($urandom_range(0, 99999));
        default: pick = $urandom >> $urandom_range(0, 31);
      endcase
      if (n >= RANDOM_NUMS - 40) quiet_tail = 1'b1;
      render_decimal(pick);
      send_number(pick);
    end
    in_ch.valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d numbers (sign, zero and width extremes plus random) giving %0d chars.",
             nums_sent, chars_seen);
    if (fail_count == 0 && pending_chars.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
